### rtl/fsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsg_pkg;

	localparam int ROWS_DEF = 32;
	localparam int COLS_DEF = 64;

	localparam logic [1:0] KIND_PLACE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] P_AIR   = 2'd0;
	localparam logic [1:0] P_SAND  = 2'd1;
	localparam logic [1:0] P_WATER = 2'd2;
	localparam logic [1:0] P_STONE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] row;
		logic [5:0] column;
		logic [1:0] particle;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] answered_kind;
		logic [1:0] cell_value;
	} rsp_word_t;

endpackage
`default_nettype wire

### rtl/falling_sand_grid_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Falling-sand grid of ROWS x COLS two-bit cells held in two single-port-read memories (the
// grid and its working copy). After reset the block clears every entry of both memories,
// 2**(clog2(ROWS)+clog2(COLS)) of them, before it takes its first word. A place word writes
// an on-grid cell into both memories; a read word is answered from a registered grid read.
// A tick word visits every cell through one sequencer that shares the memory read port: it
// reads each cell, probes the in-grid neighbors of a sand or water cell in turn, skipping
// off-grid ones without a read, swaps on a free neighbor with two reads and two writes of the
// working grid, then copies the working grid back into the grid. The single read port of each
// memory sets the pace of a frame. One word is taken at a time.
module falling_sand_grid_step #(
	parameter int ROWS = fsg_pkg::ROWS_DEF,
	parameter int COLS = fsg_pkg::COLS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_stall,
	input  fsg_pkg::cmd_word_t cmd,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output fsg_pkg::rsp_word_t rsp
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDW   = 4'd2;
	localparam logic [3:0] S_CELL  = 4'd3;
	localparam logic [3:0] S_CELLW = 4'd4;
	localparam logic [3:0] S_NB    = 4'd5;
	localparam logic [3:0] S_NBW   = 4'd6;
	localparam logic [3:0] S_SW1   = 4'd7;
	localparam logic [3:0] S_SW2   = 4'd8;
	localparam logic [3:0] S_SW3   = 4'd9;
	localparam logic [3:0] S_SW4   = 4'd10;
	localparam logic [3:0] S_COPY  = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [2:0]    k_q;
	logic [1:0]    v_q;
	logic [1:0]    ws_q;
	logic [AW:0]   cp_q;
	logic [AW-1:0] cpa_q;
	logic          cpv_q;
	logic          rsp_valid_q;
	fsg_pkg::rsp_word_t rsp_q;

	logic [1:0] cell_mem [DEPTH];
	logic [1:0] work_mem [DEPTH];
	logic [1:0] cell_rd_q, work_rd_q;
	logic          cell_we, work_we;
	logic [AW-1:0] cell_wa, work_wa, cell_ra, work_ra;
	logic [1:0]    cell_wd, work_wd;

	logic          accept, on_grid, adv, last_cell, nb_ok, is_free, load_rsp;
	logic [AW-1:0] cmd_addr, src_addr, tgt_addr;
	logic [RW-1:0] tr;
	logic [CW-1:0] tc;
	logic [2:0]    kmax;
	fsg_pkg::rsp_word_t rsp_d;

	assign cmd_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign on_grid   = (9'(cmd.row) < 9'(ROWS)) && (9'(cmd.column) < 9'(COLS));
	assign cmd_addr  = {RW'(cmd.row), CW'(cmd.column)};
	assign src_addr  = {r_q, c_q};
	assign last_cell = (c_q == CW'(COLS - 1)) && (r_q == RW'(ROWS - 1));
	assign kmax      = (v_q == fsg_pkg::P_SAND) ? 3'd2 : 3'd4;

	always_comb begin
		tr    = (k_q < 3'd3) ? r_q + RW'(1) : r_q;
		tc    = c_q;
		nb_ok = 1'b1;
		if (k_q < 3'd3 && !(((RW+1)'(r_q) + (RW+1)'(1)) < (RW+1)'(ROWS))) begin
			nb_ok = 1'b0;
		end
		if (k_q == 3'd1 || k_q == 3'd3) begin
			tc = c_q - CW'(1);
			if (c_q == '0) begin
				nb_ok = 1'b0;
			end
		end else if (k_q == 3'd2 || k_q == 3'd4) begin
			tc = c_q + CW'(1);
			if (!(((CW+1)'(c_q) + (CW+1)'(1)) < (CW+1)'(COLS))) begin
				nb_ok = 1'b0;
			end
		end
	end
	assign tgt_addr = {tr, tc};
	assign is_free  = (v_q == fsg_pkg::P_SAND) ?
		(cell_rd_q == fsg_pkg::P_AIR || cell_rd_q == fsg_pkg::P_WATER) :
		(cell_rd_q == fsg_pkg::P_AIR);

	always_comb begin
		state_d  = state_q;
		adv      = 1'b0;
		load_rsp = 1'b0;
		rsp_d    = '0;
		cell_we  = 1'b0;
		cell_wa  = cmd_addr;
		cell_wd  = cmd.particle;
		cell_ra  = cmd_addr;
		work_we  = 1'b0;
		work_wa  = cmd_addr;
		work_wd  = cmd.particle;
		work_ra  = src_addr;
		unique case (state_q)
			S_CLEAR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				cell_wd = fsg_pkg::P_AIR;
				work_we = 1'b1;
				work_wa = clr_q;
				work_wd = fsg_pkg::P_AIR;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					rsp_d.answered_kind = cmd.kind;
					unique case (cmd.kind)
						fsg_pkg::KIND_PLACE: begin
							cell_we  = on_grid;
							work_we  = on_grid;
							load_rsp = 1'b1;
						end
						fsg_pkg::KIND_TICK: state_d = S_CELL;
						fsg_pkg::KIND_READ: begin
							if (on_grid) begin
								state_d = S_RDW;
							end else begin
								load_rsp = 1'b1;
							end
						end
						default: load_rsp = 1'b1;
					endcase
				end
			end
			S_RDW: begin
				load_rsp            = 1'b1;
				rsp_d.answered_kind = fsg_pkg::KIND_READ;
				rsp_d.cell_value    = cell_rd_q;
				state_d             = S_IDLE;
			end
			S_CELL: begin
				cell_ra = src_addr;
				state_d = S_CELLW;
			end
			S_CELLW: begin
				if (cell_rd_q == fsg_pkg::P_SAND || cell_rd_q == fsg_pkg::P_WATER) begin
					state_d = S_NB;
				end else begin
					adv = 1'b1;
				end
			end
			S_NB: begin
				cell_ra = tgt_addr;
				if (nb_ok) begin
					state_d = S_NBW;
				end else if (k_q == kmax) begin
					adv = 1'b1;
				end
			end
			S_NBW: begin
				if (is_free) begin
					state_d = S_SW1;
				end else if (k_q == kmax) begin
					adv = 1'b1;
				end else begin
					state_d = S_NB;
				end
			end
			S_SW1: begin
				work_ra = src_addr;
				state_d = S_SW2;
			end
			S_SW2: begin
				work_ra = tgt_addr;
				state_d = S_SW3;
			end
			S_SW3: begin
				work_we = 1'b1;
				work_wa = src_addr;
				work_wd = work_rd_q;
				state_d = S_SW4;
			end
			S_SW4: begin
				work_we = 1'b1;
				work_wa = tgt_addr;
				work_wd = ws_q;
				adv     = 1'b1;
			end
			S_COPY: begin
				work_ra = cp_q[AW-1:0];
				cell_we = cpv_q;
				cell_wa = cpa_q;
				cell_wd = work_rd_q;
				if (cp_q == (AW+1)'(DEPTH)) begin
					load_rsp            = 1'b1;
					rsp_d.answered_kind = fsg_pkg::KIND_TICK;
					state_d             = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (adv) begin
			state_d = last_cell ? S_COPY : S_CELL;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[work_wa] <= work_wd;
		end
		work_rd_q <= work_mem[work_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			cp_q        <= '0;
			cpv_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_IDLE) begin
				r_q   <= '0;
				c_q   <= '0;
				cp_q  <= '0;
				cpv_q <= 1'b0;
			end
			if (state_q == S_CELLW) begin
				k_q <= '0;
			end else if ((state_q == S_NB && !nb_ok) || (state_q == S_NBW && !is_free)) begin
				k_q <= k_q + 3'd1;
			end
			if (adv) begin
				c_q <= (c_q == CW'(COLS - 1)) ? '0 : c_q + CW'(1);
				if (c_q == CW'(COLS - 1)) begin
					r_q <= r_q + RW'(1);
				end
			end
			if (state_q == S_COPY) begin
				cp_q  <= cp_q + (AW+1)'(1);
				cpv_q <= 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CELLW) begin
			v_q <= cell_rd_q;
		end
		if (state_q == S_SW2) begin
			ws_q <= work_rd_q;
		end
		if (state_q == S_COPY) begin
			cpa_q <= cp_q[AW-1:0];
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (state_q == S_IDLE))
		else $error("result held while a word is in progress");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW3) |-> ($past(state_q) == S_SW2))
		else $error("swap write without both reads");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NB || state_q == S_NBW) |-> (k_q <= kmax))
		else $error("neighbor probe beyond the last candidate");

	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ($past(state_q) != S_CLEAR || state_q == S_IDLE) && !rsp_valid_q
			|| accept && rsp_valid_q && !rsp_stall)
		else $error("word taken while busy");

endmodule
`default_nettype wire
